@@ rtl/blsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package blsc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_BITS       = 12;
  localparam int ADDR_BITS      = 22;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_ADDR_BITS  = 4;
  localparam int CFG_DATA_BITS  = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [DIM_BITS-1:0]   RST_SCREEN_WIDTH  = 12'd640;
  localparam logic [DIM_BITS-1:0]   RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [COLOR_BITS-1:0] RST_DRAW_COLOR    = 32'hFF00_00FF;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DRAW_COLOR    = 2'd2;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  // status of one pixel record between stepper and address pipeline
  typedef struct packed {
    logic live;   // 0 for a step taken while idle
    logic last;
  } pix_flags_t;

endpackage

`default_nettype wire

@@ rtl/blsc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blsc_front import blsc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IN_BITS    = ((4 * COORD_BITS) + 7) / 8 * 8,
  parameter int ITEM_BITS  = 6 * COORD_BITS + 5
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [IN_BITS-1:0]   in_tdata,
  input  wire                  in_tuser,
  output logic                 fe_valid,
  input  wire                  fe_ready,
  output logic [ITEM_BITS-1:0] fe_data
);

  localparam int C = COORD_BITS;

  logic                 fe_valid_r, fe_valid_nxt;
  logic [ITEM_BITS-1:0] fe_data_r;

  logic [C-1:0]        xs, ys, xe, ye;
  logic signed [C:0]   dx, dy;
  logic [C:0]          adx, ady;
  kind_t               kind;
  logic                take;

  assign xs   = in_tdata[C-1:0];
  assign ys   = in_tdata[2*C-1:C];
  assign xe   = in_tdata[3*C-1:2*C];
  assign ye   = in_tdata[4*C-1:3*C];
  assign kind = kind_t'(in_tuser);

  // deltas are one bit wider than the coordinates
  assign dx  = $signed({xe[C-1], xe}) - $signed({xs[C-1], xs});
  assign dy  = $signed({ye[C-1], ye}) - $signed({ys[C-1], ys});
  assign adx = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
  assign ady = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);

  assign in_tready = !fe_valid_r || fe_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    fe_valid_nxt = fe_valid_r;
    if (take) begin
      fe_valid_nxt = 1'b1;
    end else if (fe_ready) begin
      fe_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fe_data_r <= {kind, dx[C], dy[C], ady, adx, ye, xe, ys, xs};
    end
  end

  assign fe_valid = fe_valid_r;
  assign fe_data  = fe_data_r;

endmodule

`default_nettype wire

@@ rtl/blsc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blsc_queue import blsc_pkg::*; #(
  parameter int WIDTH = 6 * COORD_BITS_DEF + 5
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_valid,
  output logic             wr_ready,
  input  wire  [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  wire              rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_wr, do_rd;

  assign wr_ready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/blsc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blsc_step import blsc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITEM_BITS  = 6 * COORD_BITS + 5
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  output logic                 q_ready,
  input  wire  [ITEM_BITS-1:0] q_data,
  output logic                 p_valid,
  input  wire                  p_ready,
  output logic [COORD_BITS-1:0] p_x,
  output logic [COORD_BITS-1:0] p_y,
  output pix_flags_t           p_flags
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  // unpacked queue item
  logic         q_kind_bit, q_xneg, q_yneg;
  logic [C:0]   q_ady, q_adx;
  logic [C-1:0] q_ye, q_xe, q_ys, q_xs;
  kind_t        q_kind;

  assign {q_kind_bit, q_xneg, q_yneg, q_ady, q_adx, q_ye, q_xe, q_ys, q_xs} = q_data;
  assign q_kind = kind_t'(q_kind_bit);

  // line state
  logic [C-1:0]         cur_x_r, cur_x_nxt;
  logic [C-1:0]         cur_y_r, cur_y_nxt;
  logic [C-1:0]         major_end_r, major_end_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic signed [EW-1:0] inc_s_r, inc_s_nxt;
  logic signed [EW-1:0] inc_d_r, inc_d_nxt;
  logic                 x_neg_r, x_neg_nxt;
  logic                 y_neg_r, y_neg_nxt;
  logic                 y_major_r, y_major_nxt;
  logic                 active_r, active_nxt;

  // pixel record register
  logic         p_valid_r, p_valid_nxt;
  logic [C-1:0] p_x_r, p_x_nxt;
  logic [C-1:0] p_y_r, p_y_nxt;
  pix_flags_t   p_flags_r, p_flags_nxt;

  logic                 st_fire, is_start, is_step;
  logic                 ld_y_major;
  logic [C:0]           ld_min, ld_max;
  logic signed [EW-1:0] ld_inc_s, ld_err, ld_inc_d;
  logic [C-1:0]         x_adv, y_adv, next_major;
  logic                 err_neg, at_end;

  assign q_ready  = !p_valid_r || p_ready;
  assign st_fire  = q_valid && q_ready;
  assign is_start = (q_kind == KIND_START);
  assign is_step  = (q_kind == KIND_STEP);

  // setup for a start item
  assign ld_y_major = (q_adx < q_ady);
  assign ld_min     = ld_y_major ? q_adx : q_ady;
  assign ld_max     = ld_y_major ? q_ady : q_adx;
  assign ld_inc_s   = $signed(EW'({ld_min, 1'b0}));
  assign ld_err     = ld_inc_s - $signed(EW'(ld_max));
  assign ld_inc_d   = ld_inc_s - $signed(EW'({ld_max, 1'b0}));

  // one step along the line
  assign err_neg    = err_r[EW-1];
  assign x_adv      = x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
  assign y_adv      = y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
  assign next_major = y_major_r ? y_adv : x_adv;
  assign at_end     = (next_major == major_end_r);

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_end_nxt = major_end_r;
    err_nxt       = err_r;
    inc_s_nxt     = inc_s_r;
    inc_d_nxt     = inc_d_r;
    x_neg_nxt     = x_neg_r;
    y_neg_nxt     = y_neg_r;
    y_major_nxt   = y_major_r;
    active_nxt    = active_r;
    if (st_fire && is_start) begin
      cur_x_nxt     = q_xs;
      cur_y_nxt     = q_ys;
      x_neg_nxt     = q_xneg;
      y_neg_nxt     = q_yneg;
      y_major_nxt   = ld_y_major;
      inc_s_nxt     = ld_inc_s;
      inc_d_nxt     = ld_inc_d;
      err_nxt       = ld_err;
      major_end_nxt = ld_y_major ? q_ye : q_xe;
      active_nxt    = ld_y_major ? (q_ys != q_ye) : (q_xs != q_xe);
    end else if (st_fire && is_step && active_r) begin
      err_nxt = err_r + (err_neg ? inc_s_r : inc_d_r);
      if (y_major_r) begin
        cur_y_nxt = y_adv;
        cur_x_nxt = err_neg ? cur_x_r : x_adv;
      end else begin
        cur_x_nxt = x_adv;
        cur_y_nxt = err_neg ? cur_y_r : y_adv;
      end
      active_nxt = !at_end;
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_x_nxt     = p_x_r;
    p_y_nxt     = p_y_r;
    p_flags_nxt = p_flags_r;
    if (st_fire && is_step) begin
      p_valid_nxt = 1'b1;
      if (active_r) begin
        p_x_nxt          = cur_x_r;
        p_y_nxt          = cur_y_r;
        p_flags_nxt.live = 1'b1;
        p_flags_nxt.last = at_end;
      end else begin
        p_x_nxt          = '0;
        p_y_nxt          = '0;
        p_flags_nxt.live = 1'b0;
        p_flags_nxt.last = 1'b1;
      end
    end else if (p_ready) begin
      p_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      major_end_r <= '0;
      err_r       <= '0;
      inc_s_r     <= '0;
      inc_d_r     <= '0;
      x_neg_r     <= 1'b0;
      y_neg_r     <= 1'b0;
      y_major_r   <= 1'b0;
      active_r    <= 1'b0;
      p_valid_r   <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      major_end_r <= major_end_nxt;
      err_r       <= err_nxt;
      inc_s_r     <= inc_s_nxt;
      inc_d_r     <= inc_d_nxt;
      x_neg_r     <= x_neg_nxt;
      y_neg_r     <= y_neg_nxt;
      y_major_r   <= y_major_nxt;
      active_r    <= active_nxt;
      p_valid_r   <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_x_r     <= p_x_nxt;
    p_y_r     <= p_y_nxt;
    p_flags_r <= p_flags_nxt;
  end

  assign p_valid = p_valid_r;
  assign p_x     = p_x_r;
  assign p_y     = p_y_r;
  assign p_flags = p_flags_r;

  // a step while idle gives a dead record marked last
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    st_fire && is_step && !active_r |=> p_valid_r && !p_flags_r.live && p_flags_r.last)
    else $error("idle step did not give a dead last record");

  // reaching the end point stops the line
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    st_fire && is_step && active_r && at_end |=> !active_r)
    else $error("line still active after its final point");

  // only a start item can begin a line
  a_rise_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(active_r) |-> $past(st_fire && is_start))
    else $error("line became active without a start item");

endmodule

`default_nettype wire

@@ rtl/blsc_addr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blsc_addr import blsc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int OUT_BITS   = ((2 * COORD_BITS + ADDR_BITS + COLOR_BITS) + 7) / 8 * 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   p_valid,
  output logic                  p_ready,
  input  wire  [COORD_BITS-1:0] p_x,
  input  wire  [COORD_BITS-1:0] p_y,
  input  pix_flags_t            p_flags,
  input  wire  [DIM_BITS-1:0]   screen_width,
  input  wire  [DIM_BITS-1:0]   screen_height,
  input  wire  [COLOR_BITS-1:0] draw_color,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_BITS-1:0]   out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int C  = COORD_BITS;
  localparam int CW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

  // stage 1: clip test and row product
  logic                 s1_valid_r, s1_valid_nxt;
  logic [C-1:0]         s1_x_r, s1_y_r;
  pix_flags_t           s1_flags_r;
  logic                 s1_vis_r;
  logic [ADDR_BITS-1:0] s1_prod_r;

  // stage 2: output register
  logic                  out_valid_r, out_valid_nxt;
  logic [C-1:0]          out_x_r, out_y_r;
  logic [ADDR_BITS-1:0]  out_addr_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_vis_r, out_last_r;

  logic s1_load, s2_free, s2_load, vis;

  assign vis = p_flags.live && !p_x[C-1] && !p_y[C-1] &&
               (CW'(p_x) < CW'(screen_width)) && (CW'(p_y) < CW'(screen_height));

  assign s2_free = !out_valid_r || out_tready;
  assign p_ready = !s1_valid_r || s2_free;
  assign s1_load = p_valid && p_ready;
  assign s2_load = s1_valid_r && s2_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_free) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_x_r     <= p_x;
      s1_y_r     <= p_y;
      s1_flags_r <= p_flags;
      s1_vis_r   <= vis;
      // address wraps at the address width
      s1_prod_r  <= ADDR_BITS'(p_y) * ADDR_BITS'(screen_width);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_x_r     <= s1_x_r;
      out_y_r     <= s1_y_r;
      out_addr_r  <= s1_vis_r ? s1_prod_r + ADDR_BITS'(s1_x_r) : '0;
      out_color_r <= s1_flags_r.live ? draw_color : '0;
      out_vis_r   <= s1_vis_r;
      out_last_r  <= s1_flags_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'({out_color_r, out_addr_r, out_y_r, out_x_r});
  assign out_tuser  = out_vis_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/bresenham_line_stepper_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake                     | payload
// in_     | input     | in_tvalid / in_tready         | tdata: x_start, y_start, x_end, y_end;
//         |           |                               | tuser: op (0 start, 1 step)
// out_    | output    | out_tvalid / out_tready       | tdata: pix_x, pix_y, pixel_addr,
//         |           |                               | pixel_color; tuser: on_screen; tlast: last
// cfg_    | apb write | cfg_psel & cfg_penable &      | 0x0 screen_width, 0x4 screen_height,
//         | and read  | cfg_pwrite & cfg_pready       | 0x8 draw_color
//
// one item per clock sustained while out_tready stays high, start and step alike; a start gives no result
// a step item passes the front register, queue, stepper register, product register
// and output register on its way to out_tvalid
// the line state update (one add on the error term and one on each coordinate) is
// combinational, so steps issue back to back; the address product has a stage of
// its own
// out_tready low fills the output, product and stepper registers, then the queue and
// the front register, then drops in_tready; reset (rst_n low, synchronous) empties
// all stages, leaves the block idle and loads 640 x 480 and color 0xFF0000FF

module bresenham_line_stepper_core import blsc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IN_BITS    = ((4 * COORD_BITS) + 7) / 8 * 8,
  parameter int OUT_BITS   = ((2 * COORD_BITS + ADDR_BITS + COLOR_BITS) + 7) / 8 * 8
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [IN_BITS-1:0]      in_tdata,   // x_start, y_start, x_end, y_end
  input  wire                     in_tuser,   // op
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [OUT_BITS-1:0]     out_tdata,  // pix_x, pix_y, pixel_addr, pixel_color
  output logic                    out_tuser,  // on_screen
  output logic                    out_tlast,
  input  wire                     cfg_psel,
  input  wire                     cfg_penable,
  input  wire                     cfg_pwrite,
  input  wire  [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire  [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                    cfg_pready
);

  localparam int ITEM_BITS = 6 * COORD_BITS + 5;

  logic [DIM_BITS-1:0]   screen_width_r, screen_width_nxt;
  logic [DIM_BITS-1:0]   screen_height_r, screen_height_nxt;
  logic [COLOR_BITS-1:0] draw_color_r, draw_color_nxt;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    screen_width_nxt  = screen_width_r;
    screen_height_nxt = screen_height_r;
    draw_color_nxt    = draw_color_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SCREEN_WIDTH:  screen_width_nxt  = cfg_pwdata[DIM_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height_nxt = cfg_pwdata[DIM_BITS-1:0];
        REG_DRAW_COLOR:    draw_color_nxt    = cfg_pwdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SCREEN_WIDTH:  cfg_prdata = CFG_DATA_BITS'(screen_width_r);
      REG_SCREEN_HEIGHT: cfg_prdata = CFG_DATA_BITS'(screen_height_r);
      REG_DRAW_COLOR:    cfg_prdata = CFG_DATA_BITS'(draw_color_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      draw_color_r    <= RST_DRAW_COLOR;
    end else begin
      screen_width_r  <= screen_width_nxt;
      screen_height_r <= screen_height_nxt;
      draw_color_r    <= draw_color_nxt;
    end
  end

  logic                  fe_valid, fe_ready;
  logic [ITEM_BITS-1:0]  fe_data;
  logic                  q_valid, q_ready;
  logic [ITEM_BITS-1:0]  q_data;
  logic                  p_valid, p_ready;
  logic [COORD_BITS-1:0] p_x, p_y;
  pix_flags_t            p_flags;

  blsc_front #(
    .COORD_BITS (COORD_BITS),
    .IN_BITS    (IN_BITS),
    .ITEM_BITS  (ITEM_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fe_valid  (fe_valid),
    .fe_ready  (fe_ready),
    .fe_data   (fe_data)
  );

  blsc_queue #(
    .WIDTH (ITEM_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  blsc_step #(
    .COORD_BITS (COORD_BITS),
    .ITEM_BITS  (ITEM_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .p_valid (p_valid),
    .p_ready (p_ready),
    .p_x     (p_x),
    .p_y     (p_y),
    .p_flags (p_flags)
  );

  blsc_addr #(
    .COORD_BITS (COORD_BITS),
    .OUT_BITS   (OUT_BITS)
  ) u_addr (
    .clk           (clk),
    .rst_n         (rst_n),
    .p_valid       (p_valid),
    .p_ready       (p_ready),
    .p_x           (p_x),
    .p_y           (p_y),
    .p_flags       (p_flags),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .draw_color    (draw_color_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast)
  );

endmodule

`default_nettype wire

@@ tb/bresenham_line_stepper_core_tb.sv @@
`timescale 1ns / 1ps

module bresenham_line_stepper_core_tb;
  import blsc_pkg::*;

  localparam int CB       = COORD_BITS_DEF;
  localparam int IN_W     = ((4 * CB) + 7) / 8 * 8;
  localparam int OUT_W    = ((2 * CB + ADDR_BITS + COLOR_BITS) + 7) / 8 * 8;
  localparam int ADDR_LO  = 2 * CB;
  localparam int COLOR_LO = 2 * CB + ADDR_BITS;

  typedef struct packed {
    kind_t         op;
    logic [CB-1:0] xs;
    logic [CB-1:0] ys;
    logic [CB-1:0] xe;
    logic [CB-1:0] ye;
  } draw_cmd_t;

  typedef struct packed {
    logic [CB-1:0]         px;
    logic [CB-1:0]         py;
    logic                  vis;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] rgba;
    logic                  fin;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata = '0;   // x_start, y_start, x_end, y_end
  logic                     in_tuser = 1'b0; // op
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_W-1:0]         out_tdata;       // pix_x, pix_y, pixel_addr, pixel_color
  logic                     out_tuser;       // on_screen
  logic                     out_tlast;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  bresenham_line_stepper_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // screen setup as the block should hold it
  int              scr_w    = int'(RST_SCREEN_WIDTH);
  int              scr_h    = int'(RST_SCREEN_HEIGHT);
  logic [31:0]     scr_rgba = RST_DRAW_COLOR;

  // line walker state
  int   ln_x, ln_y, ln_end, ln_err, ln_inc_str, ln_inc_diag;
  logic ln_xneg, ln_yneg, ln_ymajor, ln_active;

  draw_cmd_t cmd_q[$];
  pixel_t    pixel_q[$];
  int        n_pushed = 0;
  int        n_taken = 0;
  int        n_err = 0;

  int tx_gap = 0, tx_quiet = 0, rx_stall = 0, rx_quiet = 0;

  initial begin
    ln_x = 0; ln_y = 0; ln_end = 0; ln_err = 0; ln_inc_str = 0; ln_inc_diag = 0;
    ln_xneg = 0; ln_yneg = 0; ln_ymajor = 0; ln_active = 0;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    n_err++;
    if (n_err <= 40)
      $display("%0t ns %s: got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic void trace_line(draw_cmd_t c);
    int x0, y0, x1, y1, adx, ady;
    pixel_t p;
    if (c.op == KIND_START) begin
      x0 = int'($signed(c.xs));
      y0 = int'($signed(c.ys));
      x1 = int'($signed(c.xe));
      y1 = int'($signed(c.ye));
      adx = x1 - x0;
      ady = y1 - y0;
      ln_xneg = adx < 0;
      ln_yneg = ady < 0;
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      ln_x = x0;
      ln_y = y0;
      if (adx < ady) begin
        ln_ymajor   = 1'b1;
        ln_inc_str  = 2 * adx;
        ln_err      = ln_inc_str - ady;
        ln_inc_diag = ln_inc_str - 2 * ady;
        ln_end      = y1;
        ln_active   = y0 != y1;
      end else begin
        ln_ymajor   = 1'b0;
        ln_inc_str  = 2 * ady;
        ln_err      = ln_inc_str - adx;
        ln_inc_diag = ln_inc_str - 2 * adx;
        ln_end      = x1;
        ln_active   = x0 != x1;
      end
      return;
    end
    p = '0;
    if (!ln_active) begin
      p.fin = 1'b1;
      pixel_q.push_back(p);
      return;
    end
    p.px   = CB'(ln_x);
    p.py   = CB'(ln_y);
    p.vis  = ln_x >= 0 && ln_y >= 0 && ln_x < scr_w && ln_y < scr_h;
    p.addr = p.vis ? ADDR_BITS'(ln_y * scr_w + ln_x) : '0;
    p.rgba = scr_rgba;
    if (ln_err < 0) begin
      ln_err += ln_inc_str;
    end else begin
      ln_err += ln_inc_diag;
      if (ln_ymajor) ln_x += ln_xneg ? -1 : 1;
      else ln_y += ln_yneg ? -1 : 1;
    end
    if (ln_ymajor) begin
      ln_y += ln_yneg ? -1 : 1;
      ln_active = ln_y != ln_end;
    end else begin
      ln_x += ln_xneg ? -1 : 1;
      ln_active = ln_x != ln_end;
    end
    p.fin = !ln_active;
    pixel_q.push_back(p);
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int clamp(int v);
    if (v < -(1 << (CB - 1))) return -(1 << (CB - 1));
    if (v > (1 << (CB - 1)) - 1) return (1 << (CB - 1)) - 1;
    return v;
  endfunction

  function automatic int rand_coord();
    int v;
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? (1 << (CB - 1)) - 1 : -(1 << (CB - 1));
    v = $urandom_range(0, (1 << CB) - 1);
    return v - (1 << (CB - 1));
  endfunction

  // anywhere on screen plus a small margin around it
  function automatic int near_screen(int lim);
    int v;
    v = $urandom_range(0, lim + 15);
    return clamp(v - 8);
  endfunction

  function automatic void add_start(int x0, int y0, int x1, int y1);
    draw_cmd_t c;
    c.op = KIND_START;
    c.xs = CB'(x0);
    c.ys = CB'(y0);
    c.xe = CB'(x1);
    c.ye = CB'(y1);
    cmd_q.push_back(c);
    n_pushed++;
  endfunction

  // coordinate fields are ignored on a step, so they carry noise
  function automatic void add_step();
    draw_cmd_t c;
    c.op = KIND_STEP;
    c.xs = CB'($urandom);
    c.ys = CB'($urandom);
    c.xe = CB'($urandom);
    c.ye = CB'($urandom);
    cmd_q.push_back(c);
    n_pushed++;
  endfunction

  task automatic fill_random(int n);
    int done, x0, y0, x1, y1, d, span, len, k, r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        if ($urandom_range(0, 1)) add_step();
        else add_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        done++;
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          x0 = near_screen(scr_w);
          y0 = near_screen(scr_h);
        end else begin
          x0 = rand_coord();
          y0 = rand_coord();
        end
        span = ($urandom_range(0, 9) == 0) ? 160 : 12;
        d = $urandom_range(0, 2 * span);
        x1 = clamp(x0 + d - span);
        d = $urandom_range(0, 2 * span);
        y1 = clamp(y0 + d - span);
        len = (x1 > x0) ? x1 - x0 : x0 - x1;
        d = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (d > len) len = d;
        r = $urandom_range(0, 9);
        if (r < 8) k = len;
        else if (r == 8) k = len + $urandom_range(1, 3);
        else k = $urandom_range(0, len);
        add_start(x0, y0, x1, y1);
        repeat (k) add_step();
        done += k + 1;
      end
    end
  endtask

  // wait until every item is taken and every pixel is back, then let the pipe settle
  task automatic drain();
    while (n_taken != n_pushed || pixel_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = int'(val[DIM_BITS-1:0]);
      REG_SCREEN_HEIGHT: scr_h = int'(val[DIM_BITS-1:0]);
      REG_DRAW_COLOR:    scr_rgba = val;
      default: ;
    endcase
  endtask

  // item driver
  always @(posedge clk) begin
    draw_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (tx_gap != 0 || cmd_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (tx_gap != 0) tx_gap <= tx_gap - 1;
      end else begin
        c = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= c.op;
        in_tdata  <= {c.ye, c.xe, c.ys, c.xs};
        if (tx_quiet != 0) begin
          tx_quiet <= tx_quiet - 1;
          tx_gap   <= 0;
        end else begin
          tx_gap <= pause_len();
          if ($urandom_range(0, 39) == 0) tx_quiet <= $urandom_range(20, 80);
        end
      end
    end
  end

  // result sink backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
    end else if (rx_stall != 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (rx_quiet != 0) begin
        rx_quiet <= rx_quiet - 1;
      end else if ($urandom_range(0, 2) == 0) begin
        rx_stall <= pause_len();
        if ($urandom_range(0, 29) == 0) rx_quiet <= $urandom_range(20, 80);
      end
    end
  end

  // monitor: check results, then predict from accepted items
  always @(posedge clk) begin
    pixel_t    want;
    draw_cmd_t c;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          report("pixel with no pending step", out_tdata[63:0], '0);
        end else begin
          want = pixel_q.pop_front();
          if (out_tdata[CB-1:0] !== want.px)
            report("pix_x", 64'(out_tdata[CB-1:0]), 64'(want.px));
          if (out_tdata[2*CB-1:CB] !== want.py)
            report("pix_y", 64'(out_tdata[2*CB-1:CB]), 64'(want.py));
          if (out_tuser !== want.vis)
            report("on_screen", 64'(out_tuser), 64'(want.vis));
          if (out_tdata[ADDR_LO+ADDR_BITS-1:ADDR_LO] !== want.addr)
            report("pixel_addr", 64'(out_tdata[ADDR_LO+ADDR_BITS-1:ADDR_LO]),
                   64'(want.addr));
          if (out_tdata[COLOR_LO+COLOR_BITS-1:COLOR_LO] !== want.rgba)
            report("pixel_color", 64'(out_tdata[COLOR_LO+COLOR_BITS-1:COLOR_LO]),
                   64'(want.rgba));
          if (out_tlast !== want.fin)
            report("last", 64'(out_tlast), 64'(want.fin));
        end
      end
      if (in_tvalid && in_tready) begin
        c.op = kind_t'(in_tuser);
        c.xs = in_tdata[CB-1:0];
        c.ys = in_tdata[2*CB-1:CB];
        c.xe = in_tdata[3*CB-1:2*CB];
        c.ye = in_tdata[4*CB-1:3*CB];
        trace_line(c);
        n_taken++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // step while idle, zero-length line
    add_step();
    add_start(0, 0, 0, 0);
    add_step();
    // x-major up-right, then one step past the end
    add_start(0, 0, 4, 2);
    repeat (5) add_step();
    // y-major with both directions negative
    add_start(3, 3, 2, 0);
    repeat (3) add_step();
    // full-range diagonal, dropped by a restart while active
    add_start(-2048, -2048, 2047, 2047);
    repeat (2) add_step();
    add_start(2047, 2047, 2044, 2044);
    repeat (3) add_step();
    // crosses the bottom-right corner of the screen
    add_start(637, 478, 642, 482);
    repeat (5) add_step();
    drain();

    write_reg(REG_SCREEN_WIDTH, 32'd2048);
    write_reg(REG_SCREEN_HEIGHT, 32'd2048);
    write_reg(REG_DRAW_COLOR, 32'hFFFF_FFFF);
    fill_random(300);
    drain();

    write_reg(REG_SCREEN_WIDTH, 32'd1);
    write_reg(REG_SCREEN_HEIGHT, 32'd1);
    write_reg(REG_DRAW_COLOR, 32'h0);
    fill_random(200);
    drain();

    write_reg(REG_SCREEN_WIDTH, 32'd16);
    write_reg(REG_SCREEN_HEIGHT, 32'd9);
    write_reg(REG_DRAW_COLOR, $urandom);
    fill_random(300);
    drain();

    write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 2048));
    write_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 2048));
    write_reg(REG_DRAW_COLOR, $urandom);
    fill_random(350);
    drain();

    write_reg(REG_SCREEN_WIDTH, 32'd640);
    write_reg(REG_SCREEN_HEIGHT, 32'd480);
    write_reg(REG_DRAW_COLOR, $urandom);
    fill_random(350);
    drain();

    if (n_err == 0) begin
      $display("bresenham_line_stepper_core: match");
    end else begin
      $display("bresenham_line_stepper_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bresenham_line_stepper_core: mismatch");
    $finish;
  end

endmodule
